### rtl/fcl_pkg.sv
// ----------------------------------------------------------------------------
// fcl_pkg
// Shared constants and types for the fern posterior classify/learn unit.
// ----------------------------------------------------------------------------
package fcl_pkg;

  localparam int NUM_TREES_DEF    = 10;
  localparam int NUM_FEATURES_DEF = 8;
  localparam int COUNT_WIDTH_DEF  = 16;

  localparam int MAX_TREES = 10;
  localparam int CODE_W    = 8;
  localparam int CODE_EXT_W = 12;   // widest code that a table row can take
  localparam int CONF_W    = 20;
  localparam int POST_W    = 17;    // Q1.16, 65536 is 1.0
  localparam int FRAC_W    = 16;

  localparam int IN_DATA_W  = MAX_TREES * CODE_W;
  localparam int IN_USER_W  = 2;
  localparam int OUT_DATA_W = 24;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 20;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_ENABLE    = 1'b0,
    CFG_THRESHOLD = 1'b1
  } cfg_idx_t;

  localparam logic [CONF_W-1:0] THRESHOLD_RST = 20'd32768;

endpackage

### rtl/fcl_ram.sv
// ----------------------------------------------------------------------------
// fcl_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module fcl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/fcl_div.sv
// ----------------------------------------------------------------------------
// fcl_div
// Restoring divider for the posterior: q = floor(num * 2^16 / den), num <= den.
// One quotient bit per cycle.
// ----------------------------------------------------------------------------
module fcl_div #(
  parameter int COUNT_WIDTH = fcl_pkg::COUNT_WIDTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [COUNT_WIDTH-1:0]      num,
  input  logic [COUNT_WIDTH:0]        den,
  output logic                        done,
  output logic [fcl_pkg::POST_W-1:0]  quot
);
  import fcl_pkg::*;

  localparam int STEP_W = $clog2(POST_W + 1);

  logic                   busy_r, busy_nxt;
  logic [STEP_W-1:0]      step_r, step_nxt;
  logic [COUNT_WIDTH:0]   rem_r, rem_nxt;
  logic [COUNT_WIDTH:0]   den_r, den_nxt;
  logic [POST_W-1:0]      quot_r, quot_nxt;
  logic [COUNT_WIDTH+1:0] trial;
  logic [COUNT_WIDTH+1:0] diff;
  logic                   ge;

  // first step tests num against den unshifted (quotient bit 16)
  assign trial = (step_r == '0) ? {1'b0, rem_r} : {rem_r, 1'b0};
  assign ge    = trial >= {1'b0, den_r};
  assign diff  = trial - {1'b0, den_r};

  always_comb begin
    busy_nxt = busy_r;
    step_nxt = step_r;
    rem_nxt  = rem_r;
    den_nxt  = den_r;
    quot_nxt = quot_r;
    done     = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      step_nxt = '0;
      rem_nxt  = {1'b0, num};
      den_nxt  = den;
    end else if (busy_r) begin
      quot_nxt = {quot_r[POST_W-2:0], ge};
      rem_nxt  = ge ? diff[COUNT_WIDTH:0] : trial[COUNT_WIDTH:0];
      step_nxt = step_r + 1'b1;
      if (step_r == STEP_W'(POST_W - 1)) begin
        busy_nxt = 1'b0;
        done     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    den_r  <= den_nxt;
    quot_r <= quot_nxt;
  end

  assign quot = {quot_r[POST_W-2:0], ge};

endmodule

### rtl/fern_posterior_classify_learn_unit.sv
// ----------------------------------------------------------------------------
// fern_posterior_classify_learn_unit
// Random-ferns ensemble classifier with online learning of per-entry counts.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per window. in_tdata holds fern_code_0..9 (8 bits each,
//           tree 0 lowest); in_tuser[0] is mode (1 learn), in_tuser[1] label.
//   out_* : one result per item: confidence, is_positive, updated.
//   cfg_* : register writes, index 0 enable, index 1 threshold (Q.16).
// After reset the table memory is swept to zero, one entry per cycle, all
// NUM_TREES * 2^NUM_FEATURES entries (2560 by default); no item is taken then.
// One item is processed at a time. The table is read one tree per cycle over
// the single read port. The next item can be taken in the cycle after the
// result is loaded. A learning update, made only on a misjudgment, adds per
// tree a read, a count update and a bit-serial division whose last step
// writes back. The result sits in an output register, so the next item is
// accepted while it waits; a stalled receiver blocks only the following
// result.
// ----------------------------------------------------------------------------
module fern_posterior_classify_learn_unit #(
  parameter int NUM_TREES    = fcl_pkg::NUM_TREES_DEF,
  parameter int NUM_FEATURES = fcl_pkg::NUM_FEATURES_DEF,
  parameter int COUNT_WIDTH  = fcl_pkg::COUNT_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_tvalid,
  output logic                              in_tready,
  input  logic [fcl_pkg::IN_DATA_W-1:0]     in_tdata,   // fern_code_0 .. fern_code_9
  input  logic [fcl_pkg::IN_USER_W-1:0]     in_tuser,   // mode, label
  output logic                              out_tvalid,
  input  logic                              out_tready,
  output logic [fcl_pkg::OUT_DATA_W-1:0]    out_tdata,  // confidence, is_positive, updated
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [fcl_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [fcl_pkg::CFG_DATA_W-1:0]    cfg_data
);
  import fcl_pkg::*;

  localparam int DEPTH  = NUM_TREES << NUM_FEATURES;
  localparam int AW     = $clog2(DEPTH);
  localparam int TW     = (NUM_TREES > 1) ? $clog2(NUM_TREES) : 1;
  localparam int TCW    = $clog2(NUM_TREES + 1);
  localparam int WORD_W = 2 * COUNT_WIDTH + POST_W;
  localparam logic [COUNT_WIDTH-1:0] CNT_MAX = '1;

  typedef enum logic [7:0] {
    S_CLEAR  = 8'b0000_0001,
    S_IDLE   = 8'b0000_0010,
    S_SUM    = 8'b0000_0100,
    S_DECIDE = 8'b0000_1000,
    S_UPD_RD = 8'b0001_0000,
    S_UPD_WT = 8'b0010_0000,
    S_DIV    = 8'b0100_0000,
    S_DONE   = 8'b1000_0000
  } state_t;

  state_t state_r, state_nxt;

  logic                enable_r;
  logic [CONF_W-1:0]   thr_r;
  logic [CODE_W-1:0]   code_r [NUM_TREES];
  logic                mode_r, label_r;
  logic [AW-1:0]       clr_r, clr_nxt;
  logic [TCW-1:0]      iss_r, iss_nxt;
  logic                rvld_r, rvld_nxt;
  logic [CONF_W-1:0]   acc_r, acc_nxt;
  logic                pos_flag_r, pos_flag_nxt;
  logic                upd_r, upd_nxt;
  logic [COUNT_WIDTH-1:0] p_r, p_nxt, n_r, n_nxt;

  logic                out_valid_r, out_valid_nxt;
  logic [OUT_DATA_W-1:0] out_data_r, out_data_nxt;

  logic                ram_we, ram_re;
  logic [AW-1:0]       ram_waddr, ram_raddr, cur_addr;
  logic [WORD_W-1:0]   ram_wdata, ram_rdata;
  logic                div_start, div_done;
  logic [POST_W-1:0]   div_q;
  logic [CODE_EXT_W-1:0] code_ext;
  logic [COUNT_WIDTH-1:0] rd_p, rd_n;
  logic                misjudge;

  assign in_tready = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;

  // entry address = tree * 2^NUM_FEATURES + code
  assign code_ext = {{(CODE_EXT_W-CODE_W){1'b0}}, code_r[iss_r[TW-1:0]]};
  assign cur_addr = AW'({iss_r[TW-1:0], code_ext[NUM_FEATURES-1:0]});

  assign rd_p = ram_rdata[POST_W+COUNT_WIDTH +: COUNT_WIDTH];
  assign rd_n = ram_rdata[POST_W +: COUNT_WIDTH];

  assign misjudge = enable_r && mode_r &&
                    ((label_r && (acc_r < thr_r)) || (!label_r && (acc_r > thr_r)));

  fcl_ram #(.WIDTH(WORD_W), .DEPTH(DEPTH)) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // divider takes the updated counts as they are latched
  fcl_div #(.COUNT_WIDTH(COUNT_WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (p_nxt),
    .den   ({1'b0, p_nxt} + {1'b0, n_nxt}),
    .done  (div_done),
    .quot  (div_q)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    iss_nxt       = iss_r;
    rvld_nxt      = 1'b0;
    acc_nxt       = acc_r;
    pos_flag_nxt  = pos_flag_r;
    upd_nxt       = upd_r;
    p_nxt         = p_r;
    n_nxt         = n_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    ram_we        = 1'b0;
    ram_waddr     = cur_addr;
    ram_wdata     = {p_r, n_r, div_q};
    ram_re        = 1'b0;
    ram_raddr     = cur_addr;
    div_start     = 1'b0;

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_r;
        ram_wdata = '0;
        clr_nxt   = clr_r + 1'b1;
        if (clr_r == AW'(DEPTH - 1)) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_tvalid) begin
          iss_nxt   = '0;
          acc_nxt   = '0;
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        if (iss_r != TCW'(NUM_TREES)) begin
          ram_re   = 1'b1;
          rvld_nxt = 1'b1;
          iss_nxt  = iss_r + 1'b1;
        end else if (!rvld_r) begin
          state_nxt = S_DECIDE;
        end
        if (rvld_r) begin
          acc_nxt = acc_r + CONF_W'(ram_rdata[POST_W-1:0]);
        end
      end
      S_DECIDE: begin
        pos_flag_nxt = !enable_r || (acc_r >= thr_r);
        upd_nxt      = misjudge;
        iss_nxt      = '0;
        state_nxt    = misjudge ? S_UPD_RD : S_DONE;
      end
      S_UPD_RD: begin
        ram_re    = 1'b1;
        state_nxt = S_UPD_WT;
      end
      S_UPD_WT: begin
        p_nxt = rd_p;
        n_nxt = rd_n;
        if (label_r) begin
          if (rd_p != CNT_MAX) p_nxt = rd_p + 1'b1;
        end else begin
          if (rd_n != CNT_MAX) n_nxt = rd_n + 1'b1;
        end
        state_nxt = S_DIV;
      end
      S_DIV: begin
        // divider was started with the new counts on entry
        if (div_done) begin
          ram_we  = 1'b1;
          iss_nxt = iss_r + 1'b1;
          state_nxt = (iss_r == TCW'(NUM_TREES - 1)) ? S_DONE : S_UPD_RD;
        end
      end
      S_DONE: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = OUT_DATA_W'({upd_r, pos_flag_r, acc_r});
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_CLEAR;
      end
    endcase

    div_start = (state_r == S_UPD_WT);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_r       <= '0;
      rvld_r      <= 1'b0;
      out_valid_r <= 1'b0;
      enable_r    <= 1'b1;
      thr_r       <= THRESHOLD_RST;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      rvld_r      <= rvld_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_valid) begin
        unique case (cfg_index)
          CFG_ENABLE:    enable_r <= cfg_data[0];
          CFG_THRESHOLD: thr_r    <= cfg_data[CONF_W-1:0];
          default:       ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      mode_r  <= in_tuser[0];
      label_r <= in_tuser[1];
      for (int t = 0; t < NUM_TREES; t++) begin
        code_r[t] <= in_tdata[t*CODE_W +: CODE_W];
      end
    end
    iss_r      <= iss_nxt;
    acc_r      <= acc_nxt;
    pos_flag_r <= pos_flag_nxt;
    upd_r      <= upd_nxt;
    p_r        <= p_nxt;
    n_r        <= n_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
